### rtl/core/rwt_pkg.sv
package rwt_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THR_W      = 28;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_MARGIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_MIN_SIDE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOST_FRAMES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BOX_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BOX_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BOX_FRAC    = 3'd7;

  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [9:0]  RST_ROI_MARGIN   = 10'd40;
  localparam logic [11:0] RST_ROI_MIN_SIDE = 12'd40;
  localparam logic [7:0]  RST_MAX_LOST     = 8'd10;

  localparam logic [1:0] OP_FRAME_START = 2'd0;
  localparam logic [1:0] OP_DETECTION   = 2'd1;
  localparam logic [1:0] OP_FRAME_END   = 2'd2;

  localparam logic [1:0] STAT_TARGET = 2'd0;
  localparam logic [1:0] STAT_OTHER  = 2'd1;
  localparam logic [1:0] STAT_MISSED = 2'd2;
  localparam logic [1:0] STAT_RESET  = 2'd3;

  localparam logic [9:0] FULL_ID      = 10'd3;
  localparam logic [7:0] LOST_SAT_MAX = 8'hFF;

  typedef struct packed {
    logic [11:0]      frame_width;
    logic [11:0]      frame_height;
    logic [9:0]       roi_margin;
    logic [11:0]      roi_min_side;
    logic [7:0]       max_lost;
    logic [11:0]      min_box_width;
    logic [11:0]      min_box_height;
    logic             frac_en;
    logic [THR_W-1:0] thr_w;
    logic [THR_W-1:0] thr_h;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  marker_id;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_width;
    logic [11:0] box_height;
  } item_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [11:0] width;
    logic [11:0] height;
    logic        is_target;
    logic [1:0]  frame_status;
    logic [9:0]  wanted_id;
  } result_t;

endpackage

### rtl/core/rwt_cfg_regs.sv
module rwt_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rwt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rwt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rwt_pkg::cfg_t                    cfg
);

  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [9:0]  roi_margin_r;
  logic [11:0] roi_min_side_r;
  logic [7:0]  max_lost_r;
  logic [11:0] min_box_width_r;
  logic [11:0] min_box_height_r;
  logic [15:0] min_box_frac_r;
  logic [rwt_pkg::THR_W-1:0] thr_w_prod;
  logic [rwt_pkg::THR_W-1:0] thr_h_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= rwt_pkg::RST_FRAME_WIDTH;
      frame_height_r   <= rwt_pkg::RST_FRAME_HEIGHT;
      roi_margin_r     <= rwt_pkg::RST_ROI_MARGIN;
      roi_min_side_r   <= rwt_pkg::RST_ROI_MIN_SIDE;
      max_lost_r       <= rwt_pkg::RST_MAX_LOST;
      min_box_width_r  <= '0;
      min_box_height_r <= '0;
      min_box_frac_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rwt_pkg::REG_FRAME_WIDTH:     frame_width_r    <= cfg_data[11:0];
        rwt_pkg::REG_FRAME_HEIGHT:    frame_height_r   <= cfg_data[11:0];
        rwt_pkg::REG_ROI_MARGIN:      roi_margin_r     <= cfg_data[9:0];
        rwt_pkg::REG_ROI_MIN_SIDE:    roi_min_side_r   <= cfg_data[11:0];
        rwt_pkg::REG_MAX_LOST_FRAMES: max_lost_r       <= cfg_data[7:0];
        rwt_pkg::REG_MIN_BOX_WIDTH:   min_box_width_r  <= cfg_data[11:0];
        rwt_pkg::REG_MIN_BOX_HEIGHT:  min_box_height_r <= cfg_data[11:0];
        rwt_pkg::REG_MIN_BOX_FRAC:    min_box_frac_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The size thresholds depend on configuration only, so the item path sees a
  // plain compare against these products.
  assign thr_w_prod = {12'd0, min_box_frac_r} * {16'd0, frame_width_r};
  assign thr_h_prod = {12'd0, min_box_frac_r} * {16'd0, frame_height_r};

  always_comb begin
    cfg.frame_width    = frame_width_r;
    cfg.frame_height   = frame_height_r;
    cfg.roi_margin     = roi_margin_r;
    cfg.roi_min_side   = roi_min_side_r;
    cfg.max_lost       = max_lost_r;
    cfg.min_box_width  = min_box_width_r;
    cfg.min_box_height = min_box_height_r;
    cfg.frac_en        = (min_box_frac_r != '0) && (frame_width_r != '0) &&
                         (frame_height_r != '0);
    cfg.thr_w          = thr_w_prod;
    cfg.thr_h          = thr_h_prod;
  end

endmodule

### rtl/core/rwt_track_core.sv
module rwt_track_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  rwt_pkg::item_t    item,
  input  rwt_pkg::cfg_t     cfg,
  output rwt_pkg::result_t  res
);

  logic [12:0] last_x_r, last_x_nxt;
  logic [12:0] last_y_r, last_y_nxt;
  logic [11:0] last_w_r, last_w_nxt;
  logic [11:0] last_h_r, last_h_nxt;
  logic        have_last_r, have_last_nxt;
  logic [7:0]  lost_r, lost_nxt;
  logic [9:0]  target_r, target_nxt;
  logic [11:0] org_x_r, org_x_nxt;
  logic [11:0] org_y_r, org_y_nxt;
  logic [12:0] pend_x_r, pend_x_nxt;
  logic [12:0] pend_y_r, pend_y_nxt;
  logic [11:0] pend_w_r, pend_w_nxt;
  logic [11:0] pend_h_r, pend_h_nxt;
  logic        seen_r, seen_nxt;
  logic        tseen_r, tseen_nxt;
  rwt_pkg::result_t res_r, res_nxt;

  logic        use_last;
  logic [14:0] x1, y1;
  logic [13:0] x2, y2;
  logic [12:0] x1c, y1c;
  logic [11:0] x2c, y2c;
  logic [14:0] wd, hd;
  logic        w_ok, h_ok;
  logic [12:0] rx, ry;
  logic [11:0] rw, rh;
  logic [12:0] gx, gy;
  logic        match;
  logic        big;
  logic [7:0]  lost_inc;

  always_comb begin
    use_last = have_last_r && (lost_r < cfg.max_lost);
    x1  = 15'(last_x_r) - 15'(cfg.roi_margin);
    y1  = 15'(last_y_r) - 15'(cfg.roi_margin);
    x2  = 14'(last_x_r) + 14'(last_w_r) + 14'(cfg.roi_margin);
    y2  = 14'(last_y_r) + 14'(last_h_r) + 14'(cfg.roi_margin);
    x1c = x1[14] ? 13'd0 : x1[12:0];
    y1c = y1[14] ? 13'd0 : y1[12:0];
    x2c = (x2 > 14'(cfg.frame_width)) ? cfg.frame_width : x2[11:0];
    y2c = (y2 > 14'(cfg.frame_height)) ? cfg.frame_height : y2[11:0];
    wd  = 15'(x2c) - 15'(x1c);
    hd  = 15'(y2c) - 15'(y1c);
    w_ok = !wd[14] && (wd[13:0] >= 14'(cfg.roi_min_side));
    h_ok = !hd[14] && (hd[13:0] >= 14'(cfg.roi_min_side));
    if (use_last && w_ok && h_ok) begin
      rx = x1c;
      ry = y1c;
      rw = wd[11:0];
      rh = hd[11:0];
    end else begin
      rx = '0;
      ry = '0;
      rw = cfg.frame_width;
      rh = cfg.frame_height;
    end

    gx = 13'(item.box_x) + 13'(org_x_r);
    gy = 13'(item.box_y) + 13'(org_y_r);
    match = (item.marker_id == target_r);
    big = ((item.box_width >= cfg.min_box_width) &&
           (item.box_height >= cfg.min_box_height)) ||
          (cfg.frac_en && (({item.box_width, 16'd0} >= cfg.thr_w) ||
                           ({item.box_height, 16'd0} >= cfg.thr_h)));
    lost_inc = (lost_r == rwt_pkg::LOST_SAT_MAX) ? lost_r : lost_r + 8'd1;
  end

  always_comb begin
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    last_w_nxt    = last_w_r;
    last_h_nxt    = last_h_r;
    have_last_nxt = have_last_r;
    lost_nxt      = lost_r;
    target_nxt    = target_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    pend_w_nxt    = pend_w_r;
    pend_h_nxt    = pend_h_r;
    seen_nxt      = seen_r;
    tseen_nxt     = tseen_r;
    res_nxt       = '0;

    case (item.operation)
      rwt_pkg::OP_FRAME_START: begin
        org_x_nxt  = rx[11:0];
        org_y_nxt  = ry[11:0];
        seen_nxt   = 1'b0;
        tseen_nxt  = 1'b0;
        pend_x_nxt = '0;
        pend_y_nxt = '0;
        pend_w_nxt = '0;
        pend_h_nxt = '0;
        res_nxt.x      = rx;
        res_nxt.y      = ry;
        res_nxt.width  = rw;
        res_nxt.height = rh;
      end
      rwt_pkg::OP_DETECTION: begin
        if (!seen_r || match) begin
          pend_x_nxt = gx;
          pend_y_nxt = gy;
          pend_w_nxt = item.box_width;
          pend_h_nxt = item.box_height;
        end
        seen_nxt = 1'b1;
        if (match) begin
          tseen_nxt = 1'b1;
          res_nxt.is_target = 1'b1;
          if ((target_r != rwt_pkg::FULL_ID) && big) begin
            target_nxt = target_r + 10'd1;
          end
        end
        res_nxt.x      = gx;
        res_nxt.y      = gy;
        res_nxt.width  = item.box_width;
        res_nxt.height = item.box_height;
      end
      rwt_pkg::OP_FRAME_END: begin
        if (seen_r) begin
          last_x_nxt    = pend_x_r;
          last_y_nxt    = pend_y_r;
          last_w_nxt    = pend_w_r;
          last_h_nxt    = pend_h_r;
          have_last_nxt = 1'b1;
          lost_nxt      = '0;
          res_nxt.frame_status = tseen_r ? rwt_pkg::STAT_TARGET : rwt_pkg::STAT_OTHER;
        end else begin
          res_nxt.frame_status = rwt_pkg::STAT_MISSED;
          if (have_last_r) begin
            lost_nxt = lost_inc;
            if (lost_inc >= cfg.max_lost) begin
              have_last_nxt = 1'b0;
              res_nxt.frame_status = rwt_pkg::STAT_RESET;
            end
          end
        end
        seen_nxt  = 1'b0;
        tseen_nxt = 1'b0;
      end
      default: ;
    endcase

    res_nxt.wanted_id = target_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_w_r    <= '0;
      last_h_r    <= '0;
      have_last_r <= 1'b0;
      lost_r      <= '0;
      target_r    <= '0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      pend_x_r    <= '0;
      pend_y_r    <= '0;
      pend_w_r    <= '0;
      pend_h_r    <= '0;
      seen_r      <= 1'b0;
      tseen_r     <= 1'b0;
    end else if (fire) begin
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_w_r    <= last_w_nxt;
      last_h_r    <= last_h_nxt;
      have_last_r <= have_last_nxt;
      lost_r      <= lost_nxt;
      target_r    <= target_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      pend_x_r    <= pend_x_nxt;
      pend_y_r    <= pend_y_nxt;
      pend_w_r    <= pend_w_nxt;
      pend_h_r    <= pend_h_nxt;
      seen_r      <= seen_nxt;
      tseen_r     <= tseen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### rtl/core/roi_window_tracker.sv
// Path: an accepted input beat is held in the input register; its result beat
// is registered in the result register. Throughput: one beat per cycle unless
// out_stall holds a full result register; the input register feeds one
// combinational update of the tracker state straight into the result register.
// Reset: synchronous, active low; clears both valid flags, the tracker state
// and the configuration registers to their defaults.
module roi_window_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [rwt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic [9:0]                      in_marker_id,
  input  logic [11:0]                     in_box_x,
  input  logic [11:0]                     in_box_y,
  input  logic [11:0]                     in_box_width,
  input  logic [11:0]                     in_box_height,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [12:0]                     out_x,
  output logic [12:0]                     out_y,
  output logic [11:0]                     out_width,
  output logic [11:0]                     out_height,
  output logic                            out_is_target,
  output logic [1:0]                      out_frame_status,
  output logic [9:0]                      out_wanted_id
);

  rwt_pkg::cfg_t    cfg;
  rwt_pkg::item_t   item_r;
  rwt_pkg::result_t res;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             advance;
  logic             fire;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.operation  <= in_operation;
      item_r.marker_id  <= in_marker_id;
      item_r.box_x      <= in_box_x;
      item_r.box_y      <= in_box_y;
      item_r.box_width  <= in_box_width;
      item_r.box_height <= in_box_height;
    end
  end

  rwt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rwt_track_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid        = out_valid_r;
  assign out_x            = res.x;
  assign out_y            = res.y;
  assign out_width        = res.width;
  assign out_height       = res.height;
  assign out_is_target    = res.is_target;
  assign out_frame_status = res.frame_status;
  assign out_wanted_id    = res.wanted_id;

endmodule

### rtl/core/rwt_checker.sv
module rwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_x,
  input logic [12:0] out_y,
  input logic [11:0] out_width,
  input logic [11:0] out_height,
  input logic        out_is_target,
  input logic [1:0]  out_frame_status,
  input logic [9:0]  out_wanted_id
);

  // A result beat held by the receiver stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_width) && $stable(out_height) && $stable(out_is_target) &&
      $stable(out_frame_status) && $stable(out_wanted_id))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the result register empty the block always takes a new beat.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // A nonzero frame status only comes with a frame end, which has no box and no target.
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status != 2'd0) |->
      (out_x == 13'd0) && (out_y == 13'd0) && (out_width == 12'd0) &&
      (out_height == 12'd0) && !out_is_target)
    else $error("frame status on a result that is not a frame end");

endmodule

bind roi_window_tracker rwt_checker u_rwt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_x            (out_x),
  .out_y            (out_y),
  .out_width        (out_width),
  .out_height       (out_height),
  .out_is_target    (out_is_target),
  .out_frame_status (out_frame_status),
  .out_wanted_id    (out_wanted_id)
);
